[rtl/rghht_pkg.sv]
// Shared types, constants and the arctangent table for the handle hit test.
package rghht_pkg;

  localparam int COORD_FRAC_BITS = 4;
  localparam int CORDIC_STAGES   = 16;
  localparam int TABLE_LEN       = 24;

  // Widths: doubled point, geometry, CORDIC x/y and angle, offsets, products
  localparam int PW   = 21;
  localparam int GW   = 22;
  localparam int XW   = 33;
  localparam int ZW   = 26;
  localparam int IW   = 5;
  localparam int OW   = 23;
  localparam int MW   = OW + XW;
  localparam int RW   = 28;
  localparam int DW   = 29;
  localparam int SQW  = 56;
  localparam int SUMW = 57;
  localparam int R2W  = 26;
  localparam int NUM_HANDLES = 9;

  localparam logic signed [XW-1:0] GAIN_Q30 = 33'sd652032874;
  localparam int HANDLE_OFF = 24 * 2 * (1 << COORD_FRAC_BITS);

  localparam logic signed [17:0] FULL_TURN    = 18'sd23040;
  localparam logic signed [17:0] QUARTER_TURN = 18'sd5760;
  localparam logic signed [17:0] EIGHTH_TURN  = 18'sd2880;

  typedef enum logic [2:0] {
    REG_RECT_X        = 3'd0,
    REG_RECT_Y        = 3'd1,
    REG_RECT_W        = 3'd2,
    REG_RECT_H        = 3'd3,
    REG_ROTATION      = 3'd4,
    REG_HANDLE_RADIUS = 3'd5
  } cfg_reg_t;

  typedef enum logic [3:0] {
    HIT_NONE   = 4'd0,
    HIT_ROTATE = 4'd1,
    HIT_TL     = 4'd2,
    HIT_TR     = 4'd3,
    HIT_BR     = 4'd4,
    HIT_BL     = 4'd5,
    HIT_TOP    = 4'd6,
    HIT_RIGHT  = 4'd7,
    HIT_BOTTOM = 4'd8,
    HIT_LEFT   = 4'd9
  } hit_t;

  // One word travelling down the CORDIC row
  typedef struct packed {
    logic                 valid;
    logic                 rot;
    logic [1:0]           quad;
    logic signed [PW-1:0] px;
    logic signed [PW-1:0] py;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cord_t;

  // Rectangle geometry at doubled scale
  typedef struct packed {
    logic signed [GW-1:0] left;
    logic signed [GW-1:0] top;
    logic signed [GW-1:0] right;
    logic signed [GW-1:0] bottom;
    logic signed [GW-1:0] cx;
    logic signed [GW-1:0] cy;
    logic signed [GW-1:0] rtop;
    logic [R2W-1:0]       r2;
  } geom_t;

  // atan(2^-i) in units of 2^-18 degree
  function automatic logic signed [ZW-1:0] atan_lut(input logic [IW-1:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:  v = 26'sd11796480;
      5'd1:  v = 26'sd6963869;
      5'd2:  v = 26'sd3679517;
      5'd3:  v = 26'sd1867780;
      5'd4:  v = 26'sd937515;
      5'd5:  v = 26'sd469214;
      5'd6:  v = 26'sd234664;
      5'd7:  v = 26'sd117339;
      5'd8:  v = 26'sd58671;
      5'd9:  v = 26'sd29335;
      5'd10: v = 26'sd14668;
      5'd11: v = 26'sd7334;
      5'd12: v = 26'sd3667;
      5'd13: v = 26'sd1833;
      5'd14: v = 26'sd917;
      5'd15: v = 26'sd458;
      5'd16: v = 26'sd229;
      5'd17: v = 26'sd115;
      5'd18: v = 26'sd57;
      5'd19: v = 26'sd29;
      5'd20: v = 26'sd14;
      5'd21: v = 26'sd7;
      5'd22: v = 26'sd4;
      5'd23: v = 26'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[rtl/rghht_cordic_cell.sv]
// One CORDIC micro-rotation cell of the row.
module rghht_cordic_cell import rghht_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic [IW-1:0] stage_idx,
  input  cord_t         din,
  output cord_t         dout
);

  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic signed [ZW-1:0] at;
  cord_t                nxt;

  // Rotate towards zero residual angle
  always_comb begin
    xs  = din.x >>> stage_idx;
    ys  = din.y >>> stage_idx;
    at  = atan_lut(stage_idx);
    nxt = din;
    if (!din.z[ZW-1]) begin
      nxt.x = din.x - ys;
      nxt.y = din.y + xs;
      nxt.z = din.z - at;
    end else begin
      nxt.x = din.x + ys;
      nxt.y = din.y - xs;
      nxt.z = din.z + at;
    end
  end

  // Advance the word to the neighbour
  always_ff @(posedge clk) begin
    if (rst) dout.valid <= 1'b0;
    else if (adv) dout <= nxt;
  end

endmodule

[rtl/rghht_rotate.sv]
// Quadrant fix-up, offset rotation and rounding back to the centre.
module rghht_rotate import rghht_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  cord_t                din,
  input  geom_t                geom,
  output logic                 valid,
  output logic signed [RW-1:0] rx,
  output logic signed [RW-1:0] ry
);

  logic signed [XW-1:0]   c;
  logic signed [XW-1:0]   s;
  logic signed [OW-1:0]   dx;
  logic signed [OW-1:0]   dy;
  logic                   v1;
  logic                   rot1;
  logic signed [PW-1:0]   px1;
  logic signed [PW-1:0]   py1;
  logic signed [MW-1:0]   pxc;
  logic signed [MW-1:0]   pys;
  logic signed [MW-1:0]   pxs;
  logic signed [MW-1:0]   pyc;
  logic signed [SUMW-1:0] sumx;
  logic signed [SUMW-1:0] sumy;
  logic signed [RW-1:0]   rx_next;
  logic signed [RW-1:0]   ry_next;

  // Apply the quadrant and form offsets from the centre
  always_comb begin
    case (din.quad)
      2'd0:    begin c = din.x;  s = din.y;  end
      2'd1:    begin c = -din.y; s = din.x;  end
      2'd2:    begin c = -din.x; s = -din.y; end
      2'd3:    begin c = din.y;  s = -din.x; end
      default: begin c = din.x;  s = din.y;  end
    endcase
    dx = OW'(din.px) - OW'(geom.cx);
    dy = OW'(din.py) - OW'(geom.cy);
  end

  // Register the four products
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1   <= din.valid;
      rot1 <= din.rot;
      px1  <= din.px;
      py1  <= din.py;
      pxc  <= MW'(dx) * MW'(c);
      pys  <= MW'(dy) * MW'(s);
      pxs  <= MW'(dx) * MW'(s);
      pyc  <= MW'(dy) * MW'(c);
    end
  end

  // Round half up and add back to the centre; an unrotated point passes exact
  always_comb begin
    sumx = SUMW'(pxc) - SUMW'(pys) + (SUMW'(1) <<< 29);
    sumy = SUMW'(pxs) + SUMW'(pyc) + (SUMW'(1) <<< 29);
    if (rot1) begin
      rx_next = RW'(geom.cx) + RW'(signed'(sumx[SUMW-1:30]));
      ry_next = RW'(geom.cy) + RW'(signed'(sumy[SUMW-1:30]));
    end else begin
      rx_next = RW'(px1);
      ry_next = RW'(py1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= v1;
      rx    <= rx_next;
      ry    <= ry_next;
    end
  end

endmodule

[rtl/rghht_hit.sv]
// Squared distance to the nine handles and first-hit selection.
module rghht_hit import rghht_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 din_valid,
  input  logic signed [RW-1:0] rx,
  input  logic signed [RW-1:0] ry,
  input  geom_t                geom,
  output logic                 out_valid,
  output logic [3:0]           handle_hit
);

  logic signed [GW-1:0]   hx [NUM_HANDLES];
  logic signed [GW-1:0]   hy [NUM_HANDLES];
  logic                   v1;
  logic                   v2;
  logic signed [DW-1:0]   ddx [NUM_HANDLES];
  logic signed [DW-1:0]   ddy [NUM_HANDLES];
  logic signed [2*DW-1:0] fx  [NUM_HANDLES];
  logic signed [2*DW-1:0] fy  [NUM_HANDLES];
  logic [SQW-1:0]         sqx [NUM_HANDLES];
  logic [SQW-1:0]         sqy [NUM_HANDLES];
  logic [SUMW-1:0]        d2  [NUM_HANDLES];
  logic [NUM_HANDLES-1:0] near;
  hit_t                   hit_next;

  // Handle centres in test order
  always_comb begin
    hx[0] = geom.cx;    hy[0] = geom.rtop;
    hx[1] = geom.left;  hy[1] = geom.top;
    hx[2] = geom.right; hy[2] = geom.top;
    hx[3] = geom.right; hy[3] = geom.bottom;
    hx[4] = geom.left;  hy[4] = geom.bottom;
    hx[5] = geom.cx;    hy[5] = geom.top;
    hx[6] = geom.right; hy[6] = geom.cy;
    hx[7] = geom.cx;    hy[7] = geom.bottom;
    hx[8] = geom.left;  hy[8] = geom.cy;
  end

  // Register the differences, then the squares
  always_comb begin
    for (int k = 0; k < NUM_HANDLES; k++) begin
      fx[k] = (2*DW)'(ddx[k]) * (2*DW)'(ddx[k]);
      fy[k] = (2*DW)'(ddy[k]) * (2*DW)'(ddy[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (adv) begin
      v1 <= din_valid;
      v2 <= v1;
      for (int k = 0; k < NUM_HANDLES; k++) begin
        ddx[k] <= DW'(rx) - DW'(hx[k]);
        ddy[k] <= DW'(ry) - DW'(hy[k]);
        sqx[k] <= fx[k][SQW-1:0];
        sqy[k] <= fy[k][SQW-1:0];
      end
    end
  end

  // Compare against the radius; the first handle in order wins
  always_comb begin
    hit_next = HIT_NONE;
    for (int k = 0; k < NUM_HANDLES; k++) begin
      d2[k]   = SUMW'(sqx[k]) + SUMW'(sqy[k]);
      near[k] = d2[k] <= SUMW'(geom.r2);
    end
    if      (near[0]) hit_next = HIT_ROTATE;
    else if (near[1]) hit_next = HIT_TL;
    else if (near[2]) hit_next = HIT_TR;
    else if (near[3]) hit_next = HIT_BR;
    else if (near[4]) hit_next = HIT_BL;
    else if (near[5]) hit_next = HIT_TOP;
    else if (near[6]) hit_next = HIT_RIGHT;
    else if (near[7]) hit_next = HIT_BOTTOM;
    else if (near[8]) hit_next = HIT_LEFT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid  <= v2;
      handle_hit <= hit_next;
    end
  end

endmodule

[rtl/rotated_gizmo_handle_hit_test_top.sv]
// Top level of the rotated gizmo handle hit test.
//
// Input channel: in_valid / in_stall with point_x, point_y (signed, 4 fraction
// bits). Output channel: out_valid / out_stall with handle_hit (0 none,
// 1 rotate, 2..5 corners TL TR BR BL, 6..9 edges top right bottom left).
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Write the registers only while no word is in flight.
//
// One word is taken every cycle while no result waits with out_stall high. The
// word is registered in each cell of the CORDIC row, in the offset rotation
// (products, then rounding) and in the handle test (differences, squares,
// compare and select).
// The whole pipeline advances together: while a result waits with out_stall
// high, in_stall is high and nothing moves; words keep their places.
// Reset clears all valid flags and loads the register reset values
// (handle_radius 128, everything else zero).
module rotated_gizmo_handle_hit_test_top import rghht_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [19:0] point_x,
  input  logic signed [19:0] point_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         handle_hit,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [19:0]        cfg_data
);

  logic signed [19:0] rect_x;
  logic signed [19:0] rect_y;
  logic [18:0]        rect_w;
  logic [18:0]        rect_h;
  logic signed [15:0] rotation_angle;
  logic [11:0]        handle_radius;

  logic               adv;
  geom_t              geom;
  logic [12:0]        rad2;
  logic signed [17:0] av;
  logic signed [17:0] ar;
  logic signed [17:0] rr;
  logic [1:0]         quad;
  cord_t              chain [CORDIC_STAGES+1];
  logic               rot_valid;
  logic signed [RW-1:0] rot_x;
  logic signed [RW-1:0] rot_y;

  assign cfg_ready = 1'b1;
  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rect_x         <= '0;
      rect_y         <= '0;
      rect_w         <= '0;
      rect_h         <= '0;
      rotation_angle <= '0;
      handle_radius  <= 12'd128;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_RECT_X:        rect_x         <= cfg_data;
        REG_RECT_Y:        rect_y         <= cfg_data;
        REG_RECT_W:        rect_w         <= cfg_data[18:0];
        REG_RECT_H:        rect_h         <= cfg_data[18:0];
        REG_ROTATION:      rotation_angle <= cfg_data[15:0];
        REG_HANDLE_RADIUS: handle_radius  <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // Rectangle geometry at doubled scale
  always_comb begin
    rad2        = {handle_radius, 1'b0};
    geom.left   = GW'(rect_x) <<< 1;
    geom.top    = GW'(rect_y) <<< 1;
    geom.right  = geom.left + signed'({2'b00, rect_w, 1'b0});
    geom.bottom = geom.top + signed'({2'b00, rect_h, 1'b0});
    geom.cx     = geom.left + signed'({3'b000, rect_w});
    geom.cy     = geom.top + signed'({3'b000, rect_h});
    geom.rtop   = geom.top - GW'(HANDLE_OFF);
    geom.r2     = R2W'(rad2) * R2W'(rad2);
  end

  // Reduce the negated angle to a quadrant and a residual within an eighth turn
  always_comb begin
    av = 18'sd46080 - 18'(rotation_angle);
    if (av >= 18'sd69120)      ar = av - 18'sd69120;
    else if (av >= 18'sd46080) ar = av - 18'sd46080;
    else if (av >= FULL_TURN)  ar = av - FULL_TURN;
    else                       ar = av;
    if (ar >= 18'sd17280) begin
      quad = 2'd3; rr = ar - 18'sd17280;
    end else if (ar >= 18'sd11520) begin
      quad = 2'd2; rr = ar - 18'sd11520;
    end else if (ar >= QUARTER_TURN) begin
      quad = 2'd1; rr = ar - QUARTER_TURN;
    end else begin
      quad = 2'd0; rr = ar;
    end
    if (rr >= EIGHTH_TURN) begin
      quad = quad + 2'd1;
      rr   = rr - QUARTER_TURN;
    end
  end

  // Word entering the row
  always_comb begin
    chain[0].valid = in_valid;
    chain[0].rot   = rotation_angle != '0;
    chain[0].quad  = quad;
    chain[0].px    = PW'(point_x) <<< 1;
    chain[0].py    = PW'(point_y) <<< 1;
    chain[0].x     = GAIN_Q30;
    chain[0].y     = '0;
    chain[0].z     = ZW'(rr) <<< 12;
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    rghht_cordic_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .stage_idx (IW'(i)),
      .din       (chain[i]),
      .dout      (chain[i+1])
    );
  end

  rghht_rotate u_rotate (
    .clk   (clk),
    .rst   (rst),
    .adv   (adv),
    .din   (chain[CORDIC_STAGES]),
    .geom  (geom),
    .valid (rot_valid),
    .rx    (rot_x),
    .ry    (rot_y)
  );

  rghht_hit u_hit (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .din_valid  (rot_valid),
    .rx         (rot_x),
    .ry         (rot_y),
    .geom       (geom),
    .out_valid  (out_valid),
    .handle_hit (handle_hit)
  );

endmodule

[rtl/rghht_checker.sv]
// Port-level checks on the handle hit test, bound to the top level.
module rghht_checker import rghht_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] handle_hit
);

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word present after reset");

  // Input is held back only by a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a waiting result");

  // A waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(handle_hit)))
    else $error("stalled result word changed");

  // Only codes 0..9 leave the block
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (handle_hit <= HIT_LEFT))
    else $error("handle code out of range");

endmodule

bind rotated_gizmo_handle_hit_test_top rghht_checker u_rghht_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .handle_hit (handle_hit)
);
